FILE: src/hcbd_pkg.sv
// hcbd_pkg: shared types, phase codes and byte constants for the chunked body decoder.
// No dependencies.
`timescale 1ns / 1ps

package hcbd_pkg;

  localparam int SIZE_BITS_DEFAULT = 32;

  localparam logic [2:0] PH_HDR       = 3'd0;
  localparam logic [2:0] PH_HDR_SKIP  = 3'd1;
  localparam logic [2:0] PH_SIZE      = 3'd2;
  localparam logic [2:0] PH_SIZE_SKIP = 3'd3;
  localparam logic [2:0] PH_BODY      = 3'd4;
  localparam logic [2:0] PH_TRAIL     = 3'd5;
  localparam logic [2:0] PH_DONE      = 3'd6;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [1:0] TRAIL_LEN = 2'd2;

  typedef struct packed {
    logic [2:0] phase;
    logic       line_nonempty;
    logic       hex_stopped;
    logic [1:0] skip_count;
  } ctrl_t;

  localparam ctrl_t CTRL_RESET = '{phase: PH_HDR, line_nonempty: 1'b0,
                                   hex_stopped: 1'b0, skip_count: 2'd0};

  typedef struct packed {
    logic       emit;
    logic [7:0] body_byte;
    logic       end_of_body;
    logic       size_error;
  } result_t;

  function automatic logic is_hex(input logic [7:0] b);
    logic r;
    r = (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    return r;
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    if (b inside {[8'h30:8'h39]}) begin
      v = b - 8'h30;
    end else if (b inside {[8'h41:8'h46]}) begin
      v = b - 8'h37;
    end else begin
      v = b - 8'h57;
    end
    return v[3:0];
  endfunction

endpackage

FILE: src/hcbd_step.sv
// hcbd_step: combinational parser step, one byte against the current parser state.
// Depends on hcbd_pkg.
`timescale 1ns / 1ps

module hcbd_step #(
  parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
  input  logic [7:0]           in_byte,
  input  logic                 start_message,
  input  hcbd_pkg::ctrl_t      ctrl,
  input  logic [SIZE_BITS-1:0] size_accum,
  input  logic [SIZE_BITS-1:0] bytes_left,
  output hcbd_pkg::ctrl_t      ctrl_next,
  output logic [SIZE_BITS-1:0] size_accum_next,
  output logic [SIZE_BITS-1:0] bytes_left_next,
  output hcbd_pkg::result_t    res
);

  hcbd_pkg::ctrl_t      cur;
  logic [SIZE_BITS-1:0] cur_size;
  logic [SIZE_BITS-1:0] cur_left;
  logic [SIZE_BITS-1:0] left_dec;
  logic [1:0]           skip_dec;
  logic                 is_delim;

  always_comb begin
    cur      = start_message ? hcbd_pkg::CTRL_RESET : ctrl;
    cur_size = start_message ? '0 : size_accum;
    cur_left = start_message ? '0 : bytes_left;
    left_dec = cur_left - {{(SIZE_BITS-1){1'b0}}, 1'b1};
    skip_dec = cur.skip_count - 2'd1;
    is_delim = (in_byte == hcbd_pkg::CHAR_CR) || (in_byte == hcbd_pkg::CHAR_LF);

    ctrl_next       = cur;
    size_accum_next = cur_size;
    bytes_left_next = cur_left;
    res             = '0;

    case (cur.phase)
      hcbd_pkg::PH_HDR: begin
        if (is_delim) begin
          ctrl_next.phase = hcbd_pkg::PH_HDR_SKIP;
        end else begin
          ctrl_next.line_nonempty = 1'b1;
        end
      end
      hcbd_pkg::PH_HDR_SKIP: begin
        if (cur.line_nonempty) begin
          ctrl_next.phase = hcbd_pkg::PH_HDR;
        end else begin
          ctrl_next.phase       = hcbd_pkg::PH_SIZE;
          ctrl_next.hex_stopped = 1'b0;
          size_accum_next       = '0;
        end
        ctrl_next.line_nonempty = 1'b0;
      end
      hcbd_pkg::PH_SIZE: begin
        if (is_delim) begin
          if (cur_size == '0) begin
            ctrl_next.phase = hcbd_pkg::PH_DONE;
            res.emit        = 1'b1;
            res.end_of_body = 1'b1;
          end else begin
            ctrl_next.phase = hcbd_pkg::PH_SIZE_SKIP;
          end
        end else if (!cur.hex_stopped) begin
          if (!hcbd_pkg::is_hex(in_byte)) begin
            ctrl_next.hex_stopped = 1'b1;
          end else if (cur_size[SIZE_BITS-1 -: 4] != 4'd0) begin
            ctrl_next.phase = hcbd_pkg::PH_DONE;
            res.emit        = 1'b1;
            res.end_of_body = 1'b1;
            res.size_error  = 1'b1;
          end else begin
            size_accum_next = {cur_size[SIZE_BITS-5:0], hcbd_pkg::hex_val(in_byte)};
          end
        end
      end
      hcbd_pkg::PH_SIZE_SKIP: begin
        bytes_left_next = cur_size;
        ctrl_next.phase = hcbd_pkg::PH_BODY;
      end
      hcbd_pkg::PH_BODY: begin
        bytes_left_next = left_dec;
        if (left_dec == '0) begin
          ctrl_next.phase      = hcbd_pkg::PH_TRAIL;
          ctrl_next.skip_count = hcbd_pkg::TRAIL_LEN;
        end
        res.emit      = 1'b1;
        res.body_byte = in_byte;
      end
      hcbd_pkg::PH_TRAIL: begin
        ctrl_next.skip_count = skip_dec;
        if (skip_dec == 2'd0) begin
          ctrl_next.phase       = hcbd_pkg::PH_SIZE;
          ctrl_next.hex_stopped = 1'b0;
          size_accum_next       = '0;
        end
      end
      default: begin
        ctrl_next.phase = hcbd_pkg::PH_DONE;
      end
    endcase
  end

endmodule

FILE: src/hcbd_out_reg.sv
// hcbd_out_reg: result register; frees the input side whenever the slot is empty or being taken.
// Depends on hcbd_pkg.
`timescale 1ns / 1ps

module hcbd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  hcbd_pkg::result_t res,
  output logic              slot_free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        body_byte,
  output logic              end_of_body,
  output logic              size_error
);

  logic       valid;
  logic [7:0] data_byte;
  logic       data_eob;
  logic       data_err;

  assign slot_free   = !valid || out_ready;
  assign out_valid   = valid;
  assign body_byte   = data_byte;
  assign end_of_body = data_eob;
  assign size_error  = data_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load && res.emit) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.emit) begin
      data_byte <= res.body_byte;
      data_eob  <= res.end_of_body;
      data_err  <= res.size_error;
    end
  end

endmodule

FILE: src/http_chunked_body_decoder.sv
// http_chunked_body_decoder: top level of the chunked transfer body decoder.
// Depends on hcbd_pkg, hcbd_step and hcbd_out_reg.
//
//   channel | signals                            | role
//   --------+------------------------------------+------------------------------
//   in      | in_valid in_ready in_byte          | message bytes, headers included
//           | start_message                      | restart flag on first byte
//   out     | out_valid out_ready body_byte      | body bytes and end marker
//           | end_of_body size_error             |
//
// One item per cycle while in_ready is high; a result appears in the cycle after
// its item is taken, as the combinational parser step feeds the result register.
// Items that produce no result leave nothing in the result register.
// Reset (synchronous, active high) clears the parser state; no clearing pass.
// in_ready drops only while a result waits and out_ready is low.
`timescale 1ns / 1ps

module http_chunked_body_decoder #(
  parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       start_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] body_byte,
  output logic       end_of_body,
  output logic       size_error
);

  hcbd_pkg::ctrl_t      ctrl;
  hcbd_pkg::ctrl_t      ctrl_next;
  logic [SIZE_BITS-1:0] size_accum;
  logic [SIZE_BITS-1:0] size_accum_next;
  logic [SIZE_BITS-1:0] bytes_left;
  logic [SIZE_BITS-1:0] bytes_left_next;
  hcbd_pkg::result_t    res;
  logic                 slot_free;
  logic                 acc;

  assign in_ready = slot_free;
  assign acc      = in_valid && slot_free;

  hcbd_step #(
    .SIZE_BITS(SIZE_BITS)
  ) u_step (
    .in_byte        (in_byte),
    .start_message  (start_message),
    .ctrl           (ctrl),
    .size_accum     (size_accum),
    .bytes_left     (bytes_left),
    .ctrl_next      (ctrl_next),
    .size_accum_next(size_accum_next),
    .bytes_left_next(bytes_left_next),
    .res            (res)
  );

  hcbd_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (acc),
    .res        (res),
    .slot_free  (slot_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .body_byte  (body_byte),
    .end_of_body(end_of_body),
    .size_error (size_error)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl       <= hcbd_pkg::CTRL_RESET;
      size_accum <= '0;
      bytes_left <= '0;
    end else if (acc) begin
      ctrl       <= ctrl_next;
      size_accum <= size_accum_next;
      bytes_left <= bytes_left_next;
    end
  end

  // size error only ever rides on the end marker
  assert property (@(posedge clk) disable iff (rst)
    out_valid && size_error |-> end_of_body)
    else $error("size_error without end_of_body");

  // once ended, bytes give nothing until a restart
  assert property (@(posedge clk) disable iff (rst)
    acc && !start_message && ctrl.phase == hcbd_pkg::PH_DONE |=> !out_valid)
    else $error("result produced after end of body");

  // an end marker leaves the parser in the ended phase
  assert property (@(posedge clk) disable iff (rst)
    acc && res.emit && res.end_of_body |=> ctrl.phase == hcbd_pkg::PH_DONE)
    else $error("end marker without ending the message");

  // a body byte always yields a plain data item
  assert property (@(posedge clk) disable iff (rst)
    acc && !start_message && ctrl.phase == hcbd_pkg::PH_BODY |=> out_valid && !end_of_body)
    else $error("body byte lost or marked as end");

endmodule

FILE: sim/testbench.sv
// testbench: self-checking bench for http_chunked_body_decoder.
// Feeds framed HTTP messages (headers, chunks, faults) and checks every body item.
// Depends on hcbd_pkg and http_chunked_body_decoder.
`timescale 1ns / 1ps

module testbench;

  localparam logic [7:0] CR = hcbd_pkg::CHAR_CR;
  localparam logic [7:0] LF = hcbd_pkg::CHAR_LF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 633;

  typedef struct packed {
    logic [7:0] b;
    logic       st;
  } in_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       start_message = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] body_byte;
  logic       end_of_body;
  logic       size_error;

  in_item_t           byte_queue[$];
  hcbd_pkg::result_t  expected_body[$];
  logic [7:0]         msg_q[$];
  int                 send_idle = 18;
  int                 recv_idle = 51;
  int                 errors = 0;
  int                 cycles = 0;
  bit                 in_taken = 1'b0;

  // parser state mirror
  logic [2:0]  ph = hcbd_pkg::PH_HDR;
  logic        line_seen = 1'b0;
  logic        hex_done = 1'b0;
  logic [31:0] size_acc = '0;
  logic [31:0] remain = '0;
  logic [1:0]  trail_left = '0;

  http_chunked_body_decoder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
    .start_message(start_message),
    .out_valid(out_valid), .out_ready(out_ready), .body_byte(body_byte),
    .end_of_body(end_of_body), .size_error(size_error)
  );

  always #5 clk = ~clk;

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] d;
    d = 5'd0;
    if (b >= "0" && b <= "9") d = {1'b1, 4'(b - "0")};
    else if (b >= "a" && b <= "f") d = {1'b1, 4'(b - "a" + 8'd10)};
    else if (b >= "A" && b <= "F") d = {1'b1, 4'(b - "A" + 8'd10)};
    return d;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic st,
                             output hcbd_pkg::result_t r);
    logic       delim;
    logic [4:0] d;
    r = '0;
    if (st) begin
      ph = hcbd_pkg::PH_HDR;
      line_seen = 1'b0;
      hex_done = 1'b0;
      size_acc = '0;
      remain = '0;
      trail_left = '0;
    end
    delim = (b == CR) || (b == LF);
    case (ph)
      hcbd_pkg::PH_HDR: begin
        if (delim) ph = hcbd_pkg::PH_HDR_SKIP;
        else line_seen = 1'b1;
      end
      hcbd_pkg::PH_HDR_SKIP: begin
        if (line_seen) begin
          ph = hcbd_pkg::PH_HDR;
        end else begin
          ph = hcbd_pkg::PH_SIZE;
          size_acc = '0;
          hex_done = 1'b0;
        end
        line_seen = 1'b0;
      end
      hcbd_pkg::PH_SIZE: begin
        if (delim) begin
          if (size_acc == 0) begin
            ph = hcbd_pkg::PH_DONE;
            r.emit = 1'b1;
            r.end_of_body = 1'b1;
          end else begin
            ph = hcbd_pkg::PH_SIZE_SKIP;
          end
        end else if (!hex_done) begin
          d = hex_digit(b);
          if (!d[4]) begin
            hex_done = 1'b1;
          end else if (size_acc[31:28] != 0) begin
            ph = hcbd_pkg::PH_DONE;
            r.emit = 1'b1;
            r.end_of_body = 1'b1;
            r.size_error = 1'b1;
          end else begin
            size_acc = {size_acc[27:0], d[3:0]};
          end
        end
      end
      hcbd_pkg::PH_SIZE_SKIP: begin
        remain = size_acc;
        ph = hcbd_pkg::PH_BODY;
      end
      hcbd_pkg::PH_BODY: begin
        remain = remain - 32'd1;
        if (remain == 0) begin
          ph = hcbd_pkg::PH_TRAIL;
          trail_left = hcbd_pkg::TRAIL_LEN;
        end
        r.emit = 1'b1;
        r.body_byte = b;
      end
      hcbd_pkg::PH_TRAIL: begin
        trail_left = trail_left - 2'd1;
        if (trail_left == 0) begin
          ph = hcbd_pkg::PH_SIZE;
          size_acc = '0;
          hex_done = 1'b0;
        end
      end
      default: ph = hcbd_pkg::PH_DONE;
    endcase
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit up);
    if (v < 10) return 8'("0") + 8'(v);
    return (up ? 8'("A") : 8'("a")) + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == CR || b == LF) b = 8'($urandom_range(255));
    return b;
  endfunction

  task automatic add_line_end();
    msg_q.push_back(($urandom_range(3) == 0) ? LF : CR);
    msg_q.push_back(($urandom_range(4) == 0) ? 8'($urandom_range(255)) : LF);
  endtask

  task automatic add_header();
    repeat ($urandom_range(1, 8)) msg_q.push_back(plain_byte());
    add_line_end();
  endtask

  task automatic add_size_line(input logic [31:0] n);
    logic [7:0]  digs[$];
    logic [31:0] v;
    bit          up;
    v = n;
    up = 1'($urandom_range(1));
    while (v != 0) begin
      digs.push_front(hex_char(v[3:0], up));
      v = v >> 4;
    end
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) msg_q.push_back("0");
    foreach (digs[i]) msg_q.push_back(digs[i]);
    if ($urandom_range(4) == 0) begin
      msg_q.push_back(";");
      repeat ($urandom_range(4)) msg_q.push_back(plain_byte());
    end
    add_line_end();
  endtask

  task automatic add_chunk(input int n);
    add_size_line(n);
    repeat (n) msg_q.push_back(8'($urandom_range(255)));
    if ($urandom_range(5) == 0) begin
      msg_q.push_back(8'($urandom_range(255)));
      msg_q.push_back(8'($urandom_range(255)));
    end else begin
      msg_q.push_back(CR);
      msg_q.push_back(LF);
    end
  endtask

  task automatic add_front();
    msg_q.delete();
    repeat ($urandom_range(3)) add_header();
    add_line_end();
  endtask

  task automatic flush_msg(input int keep, input bit noisy);
    for (int i = 0; i < keep; i++) begin
      byte_queue.push_back('{b: msg_q[i],
                             st: noisy ? ($urandom_range(5) == 0) : (i == 0)});
    end
  endtask

  task automatic random_items(input int target);
    int got;
    int kind;
    int n;
    got = 0;
    while (got < target) begin
      kind = $urandom_range(99);
      if (kind < 85 || kind == 99) begin
        add_front();
        repeat ($urandom_range(3)) begin
          n = ($urandom_range(9) == 0) ? $urandom_range(13, 600) : $urandom_range(1, 12);
          add_chunk(n);
        end
        add_size_line(0);
        got += msg_q.size();
        repeat ($urandom_range(2)) msg_q.push_back(8'($urandom_range(255)));
        if (kind == 99) begin
          // cut short
          n = $urandom_range(1, msg_q.size());
          flush_msg(n, 1'b0);
        end else begin
          flush_msg(msg_q.size(), 1'b0);
        end
      end else if (kind < 90) begin
        // oversized chunk size
        add_front();
        if ($urandom_range(1)) add_chunk($urandom_range(1, 5));
        msg_q.push_back(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(1))));
        repeat ($urandom_range(8, 10)) msg_q.push_back(hex_char(4'($urandom_range(15)),
                                                               1'($urandom_range(1))));
        add_line_end();
        got += msg_q.size();
        flush_msg(msg_q.size(), 1'b0);
      end else if (kind < 94) begin
        // eight digit size, body cut off early
        add_front();
        add_size_line({4'($urandom_range(1, 15)), 28'($urandom())});
        repeat ($urandom_range(1, 20)) msg_q.push_back(8'($urandom_range(255)));
        got += msg_q.size();
        flush_msg(msg_q.size(), 1'b0);
      end else begin
        msg_q.delete();
        repeat ($urandom_range(5, 20)) msg_q.push_back(8'($urandom_range(255)));
        got += msg_q.size();
        flush_msg(msg_q.size(), 1'b1);
      end
    end
  endtask

  task automatic drain();
    while (byte_queue.size() != 0 || in_valid || expected_body.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  always @(negedge clk) begin
    in_item_t it;
    out_ready <= ($urandom_range(99) >= recv_idle);
    if (!rst && (!in_valid || in_taken)) begin
      if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
        it = byte_queue.pop_front();
        in_valid <= 1'b1;
        in_byte <= it.b;
        start_message <= it.st;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    hcbd_pkg::result_t want;
    hcbd_pkg::result_t r;
    in_taken = in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_body.size() == 0) begin
          errors++;
          $display("%0t: unexpected item byte %02h eob %b err %b",
                   $time, body_byte, end_of_body, size_error);
        end else begin
          want = expected_body.pop_front();
          if (body_byte !== want.body_byte || end_of_body !== want.end_of_body ||
              size_error !== want.size_error) begin
            errors++;
            $display("%0t: expected byte %02h eob %b err %b, got byte %02h eob %b err %b",
                     $time, want.body_byte, want.end_of_body, want.size_error,
                     body_byte, end_of_body, size_error);
          end
        end
      end
      if (in_taken) begin
        decode_byte(in_byte, start_message, r);
        if (r.emit) expected_body.push_back(r);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // header, chunk with extension and extreme body bytes, end, ignored byte
    msg_q = '{"A", CR, LF, CR, LF, "2", ";", CR, LF, 8'h00, 8'hFF, CR, LF, "0", CR, 8'h55};
    flush_msg(msg_q.size(), 1'b0);
    // size overflow on the ninth digit
    msg_q = '{CR, LF, "A", "B", "C", "D", "E", "F", "0", "F", "1"};
    flush_msg(msg_q.size(), 1'b0);
    // empty size line
    msg_q = '{CR, LF, CR};
    flush_msg(msg_q.size(), 1'b0);
    random_items(ITEMS_PER_PHASE);
    drain();

    send_idle = 51;
    recv_idle = 18;
    random_items(ITEMS_PER_PHASE);
    drain();

    send_idle = 0;
    recv_idle = 0;
    random_items(ITEMS_PER_PHASE);
    drain();
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/hcbd_pkg.sv
src/hcbd_step.sv
src/hcbd_out_reg.sv
src/http_chunked_body_decoder.sv
sim/testbench.sv
